FILE: rtl/tt_pkg.sv
// tt_pkg: shared types and constants for the tap tempo beat tracker
// used by tt_div and tap_tempo_beat_tracker; depends on nothing
package tt_pkg;

  localparam int HIST_DEPTH = 8;
  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

  localparam int TS_W    = 40;
  localparam int FRAC_W  = 16;
  localparam int ANC_W   = 56;
  localparam int LEN_W   = 32;
  localparam int TMO_W   = 16;
  localparam int PHASE_W = 17;
  localparam int CNT_W   = 32;

  localparam int DIV_N_W = 56;
  localparam int DIV_D_W = 32;
  localparam int DIV_C_W = $clog2(DIV_N_W);

  localparam logic [LEN_W-1:0]   INIT_DUR_RST = 32'd65536000;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST  = 16'd2000;
  localparam logic [LEN_W-1:0]   TEMPO_RST    = 32'd3932160;
  localparam logic [DIV_N_W-1:0] TEMPO_NUM    = 56'd60000 << 32;
  localparam logic [LEN_W-1:0]   SAT32        = '1;

  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_DUR    = 1'b0,
    REG_TAP_TIMEOUT = 1'b1
  } cfg_reg_t;

  localparam logic CMD_TAP  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [TS_W-1:0] timestamp_ms;
  } evt_word_t;

  typedef struct packed {
    logic               beat_pulse;
    logic [LEN_W-1:0]   bpm_value;
    logic [CNT_W-1:0]   beat_total;
    logic [PHASE_W-1:0] beat_phase;
    logic               sync_updated;
  } res_word_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
    logic [DIV_D_W-1:0] remainder;
  } div_rsp_t;

endpackage

FILE: rtl/tt_div.sv
// tt_div: restoring divider, one quotient bit per cycle, shared by all divisions
// depends on tt_pkg
module tt_div (
  input  logic              clk,
  input  logic              rst,
  input  tt_pkg::div_req_t  req,
  output tt_pkg::div_rsp_t  rsp
);

  logic                        busy;
  logic                        done;
  logic [tt_pkg::DIV_C_W-1:0]  cnt;
  logic [tt_pkg::DIV_N_W-1:0]  quo;
  logic [tt_pkg::DIV_D_W-1:0]  rem;
  logic [tt_pkg::DIV_D_W-1:0]  dvs;
  logic [tt_pkg::DIV_D_W:0]    trial;
  logic                        fits;

  assign trial = {rem, quo[tt_pkg::DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == tt_pkg::DIV_C_W'(tt_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[tt_pkg::DIV_N_W-2:0], fits};
      rem <= fits ? tt_pkg::DIV_D_W'(trial - {1'b0, dvs}) : trial[tt_pkg::DIV_D_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

FILE: rtl/tap_tempo_beat_tracker.sv
// tap_tempo_beat_tracker: tap tempo estimation and beat phase tracking
// depends on tt_pkg and tt_div
//
//   channel | dir | payload                        | handshake
//   evt     | in  | cmd, timestamp_ms              | evt_valid / evt_ready
//   res     | out | pulse, bpm, total, phase, sync | res_valid / res_ready
//   cfg     | in  | cfg_index, cfg_data            | cfg_valid / cfg_ready
//
// a tempo-updating tap or a tick with elapsed time makes two 56-step passes through
// the shared bit-serial divider between one accept and the next
// a tap with fewer than two taps held makes none, a tick at or before the anchor one,
// a skipped tick none; a write of initial_duration makes one before the next word
// reset is synchronous; evt and cfg are not ready while an item is in work
// a finished word waits in the output register; the next word stalls behind it
module tap_tempo_beat_tracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            evt_valid,
  output logic                            evt_ready,
  input  tt_pkg::evt_word_t               evt_data,
  output logic                            res_valid,
  input  logic                            res_ready,
  output tt_pkg::res_word_t               res_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tt_pkg::LEN_W-1:0]        cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SPAN      = 8'b0000_0010,
    S_DIV_LEN   = 8'b0000_0100,
    S_DIV_TEMPO = 8'b0000_1000,
    S_DIFF      = 8'b0001_0000,
    S_DIV_BEAT  = 8'b0010_0000,
    S_DIV_PHASE = 8'b0100_0000,
    S_FINISH    = 8'b1000_0000
  } state_t;

  state_t state;

  logic [tt_pkg::TS_W-1:0]    hist [tt_pkg::HIST_DEPTH];
  logic [tt_pkg::FILL_W-1:0]  fill;
  logic [tt_pkg::TS_W-1:0]    last_tap;
  logic [tt_pkg::TMO_W-1:0]   timeout;
  logic [tt_pkg::LEN_W-1:0]   beat_length;
  logic [tt_pkg::LEN_W-1:0]   tempo;
  logic [tt_pkg::ANC_W-1:0]   anchor;
  logic                       ticking;
  logic [tt_pkg::CNT_W-1:0]   counter;
  logic [tt_pkg::PHASE_W-1:0] phase;
  logic [tt_pkg::ANC_W-1:0]   now;
  logic                       pulse;
  logic                       synced;
  logic                       from_cfg;

  tt_pkg::div_req_t div_req;
  tt_pkg::div_rsp_t div_rsp;

  logic                       idle;
  logic                       evt_take;
  logic                       cfg_take;
  logic                       res_load;
  logic [tt_pkg::TS_W-1:0]    ts;
  logic [tt_pkg::TS_W-1:0]    gap;
  logic [tt_pkg::FILL_W-1:0]  fill_eff;
  logic [tt_pkg::TS_W-1:0]    span;
  logic [tt_pkg::LEN_W-1:0]   len_sat;
  logic [tt_pkg::DIV_D_W:0]   rbeat;

  assign idle      = state == S_IDLE;
  assign cfg_ready = idle;
  assign evt_ready = idle && !cfg_valid;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign evt_take  = evt_valid && evt_ready;
  assign res_load  = state == S_FINISH && (!res_valid || res_ready);

  assign ts       = evt_data.timestamp_ms;
  assign gap      = ts - last_tap;
  assign fill_eff = (fill != '0 && ts >= last_tap &&
                     gap >= tt_pkg::TS_W'(timeout)) ? '0 : fill;
  assign span     = (last_tap >= hist[0]) ? last_tap - hist[0] : '0;
  assign len_sat  = (div_rsp.quotient[tt_pkg::DIV_N_W-1:tt_pkg::LEN_W] != '0) ?
                    tt_pkg::SAT32 : div_rsp.quotient[tt_pkg::LEN_W-1:0];
  assign rbeat    = {1'b0, div_rsp.remainder} + 1'b1;

  always_comb begin
    div_req = '0;
    unique case (state)
      S_IDLE: begin
        if (cfg_take && cfg_index == tt_pkg::REG_INIT_DUR) begin
          div_req.start    = 1'b1;
          div_req.dividend = tt_pkg::TEMPO_NUM;
          div_req.divisor  = cfg_data;
        end
      end
      S_SPAN: begin
        if (fill >= tt_pkg::FILL_W'(2)) begin
          div_req.start    = 1'b1;
          div_req.dividend = {span, {tt_pkg::FRAC_W{1'b0}}};
          div_req.divisor  = tt_pkg::DIV_D_W'(fill - 1'b1);
        end
      end
      S_DIV_LEN: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = tt_pkg::TEMPO_NUM;
        div_req.divisor  = len_sat;
      end
      S_DIFF: begin
        div_req.start    = 1'b1;
        div_req.divisor  = beat_length;
        div_req.dividend = (now > anchor) ? now + ~anchor : '0;
      end
      S_DIV_BEAT: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = tt_pkg::DIV_N_W'({rbeat, {tt_pkg::FRAC_W{1'b0}}});
        div_req.divisor  = beat_length;
      end
      S_DIV_TEMPO, S_DIV_PHASE, S_FINISH: begin
        div_req = '0;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  tt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      timeout     <= tt_pkg::TIMEOUT_RST;
      beat_length <= tt_pkg::INIT_DUR_RST;
      tempo       <= tt_pkg::TEMPO_RST;
      anchor      <= '0;
      ticking     <= 1'b0;
      counter     <= '0;
      phase       <= '0;
      from_cfg    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_take) begin
            case (cfg_index)
              tt_pkg::REG_INIT_DUR: begin
                beat_length <= cfg_data;
                from_cfg    <= 1'b1;
                state       <= S_DIV_TEMPO;
              end
              default: begin
                timeout <= cfg_data[tt_pkg::TMO_W-1:0];
              end
            endcase
          end else if (evt_take) begin
            now      <= {ts, {tt_pkg::FRAC_W{1'b0}}};
            from_cfg <= 1'b0;
            if (evt_data.cmd == tt_pkg::CMD_TAP) begin
              pulse    <= 1'b1;
              synced   <= 1'b0;
              anchor   <= {ts, {tt_pkg::FRAC_W{1'b0}}};
              last_tap <= ts;
              if (fill_eff >= tt_pkg::FILL_W'(tt_pkg::HIST_DEPTH)) begin
                for (int i = 0; i < tt_pkg::HIST_DEPTH - 1; i++) begin
                  hist[i] <= hist[i+1];
                end
                hist[tt_pkg::HIST_DEPTH-1] <= ts;
                fill <= tt_pkg::FILL_W'(tt_pkg::HIST_DEPTH);
              end else begin
                hist[fill_eff[tt_pkg::HIST_IDX_W-1:0]] <= ts;
                fill <= fill_eff + 1'b1;
              end
              state <= S_SPAN;
            end else if (beat_length == '0) begin
              pulse  <= 1'b0;
              synced <= 1'b0;
              state  <= S_FINISH;
            end else begin
              pulse  <= 1'b0;
              synced <= 1'b1;
              if (!ticking) begin
                ticking <= 1'b1;
                anchor  <= {ts, {tt_pkg::FRAC_W{1'b0}}};
                counter <= '0;
              end
              state <= S_DIFF;
            end
          end
        end
        S_SPAN: begin
          state <= (fill >= tt_pkg::FILL_W'(2)) ? S_DIV_LEN : S_FINISH;
        end
        S_DIV_LEN: begin
          if (div_rsp.done) begin
            beat_length <= len_sat;
            state       <= S_DIV_TEMPO;
          end
        end
        S_DIV_TEMPO: begin
          if (div_rsp.done) begin
            tempo <= len_sat;
            state <= from_cfg ? S_IDLE : S_FINISH;
          end
        end
        S_DIFF: begin
          state <= (now > anchor) ? S_DIV_BEAT : S_DIV_PHASE;
        end
        S_DIV_BEAT: begin
          if (div_rsp.done) begin
            pulse   <= div_rsp.quotient != '0;
            counter <= counter + div_rsp.quotient[tt_pkg::CNT_W-1:0];
            anchor  <= now - tt_pkg::ANC_W'(rbeat);
            state   <= S_DIV_PHASE;
          end
        end
        S_DIV_PHASE: begin
          if (div_rsp.done) begin
            phase <= div_rsp.quotient[tt_pkg::PHASE_W-1:0];
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data.beat_pulse   <= pulse;
      res_data.bpm_value    <= tempo;
      res_data.beat_total   <= counter;
      res_data.beat_phase   <= phase;
      res_data.sync_updated <= synced;
    end
  end

endmodule

FILE: bench/tap_tempo_beat_tracker_tb.sv
// tap_tempo_beat_tracker_tb: self-checking bench for the tap tempo beat tracker
// drives tap and tick words, rewrites both registers between phases, checks each
// result against a script or an in-bench tempo/phase tracker; needs tt_pkg
module tap_tempo_beat_tracker_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [63:0] MASK56 = 64'hFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst;
  logic evt_valid;
  logic evt_ready;
  tt_pkg::evt_word_t evt_data;
  logic res_valid;
  logic res_ready;
  tt_pkg::res_word_t res_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [tt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tt_pkg::LEN_W-1:0] cfg_data;

  tap_tempo_beat_tracker dut (
    .clk(clk), .rst(rst),
    .evt_valid(evt_valid), .evt_ready(evt_ready), .evt_data(evt_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // tracker state
  logic [tt_pkg::TS_W-1:0] tap_times [tt_pkg::HIST_DEPTH];
  int unsigned taps_held;
  logic [tt_pkg::LEN_W-1:0] beat_len;
  logic [tt_pkg::LEN_W-1:0] tempo_q;
  logic [tt_pkg::ANC_W-1:0] anchor_q;
  logic tick_seen;
  logic [tt_pkg::CNT_W-1:0] beats_q;
  logic [tt_pkg::PHASE_W-1:0] phase_q;
  logic [tt_pkg::TMO_W-1:0] timeout_q;

  tt_pkg::res_word_t pending_beats[$];
  int errors;
  bit quiet;
  int idle_cycles;
  int stall_left;

  typedef struct {
    logic cmd;
    logic [tt_pkg::TS_W-1:0] ts;
    bit typed;
    tt_pkg::res_word_t want;
  } beat_row_t;

  localparam tt_pkg::res_word_t NONE = '0;

  beat_row_t script [24] = '{
    '{tt_pkg::CMD_TICK, 40'd0,    1'b1, '{1'b0, tt_pkg::TEMPO_RST, 32'd0, 17'd0, 1'b1}},
    '{tt_pkg::CMD_TICK, 40'd1000, 1'b1, '{1'b0, tt_pkg::TEMPO_RST, 32'd0, 17'd65536, 1'b1}},
    '{tt_pkg::CMD_TICK, 40'd2500, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd3000, 1'b1, '{1'b1, tt_pkg::TEMPO_RST, 32'd2, 17'd32768, 1'b0}},
    '{tt_pkg::CMD_TAP,  40'd3500, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd4000, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd4000, 1'b0, NONE},
    '{tt_pkg::CMD_TICK, 40'd4100, 1'b0, NONE},
    '{tt_pkg::CMD_TICK, 40'd3000, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd2000, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd9000, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd9000, 1'b0, NONE},
    '{tt_pkg::CMD_TICK, 40'd9500, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd9250, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd9500, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd9750, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd10000, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd10250, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd10500, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd10750, 1'b0, NONE},
    '{tt_pkg::CMD_TICK, 40'hFF_FFFF_FFFF, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'hFF_FFFF_FFFF, 1'b0, NONE},
    '{tt_pkg::CMD_TAP,  40'd0, 1'b0, NONE},
    '{tt_pkg::CMD_TICK, 40'hAA_AAAA_AAAA, 1'b0, NONE}
  };

  function automatic logic [tt_pkg::LEN_W-1:0] tempo_for(logic [tt_pkg::LEN_W-1:0] len);
    logic [63:0] q;
    if (len == 0) return tt_pkg::SAT32;
    q = (64'd60000 << 32) / 64'(len);
    return (q > 64'hFFFF_FFFF) ? tt_pkg::SAT32 : q[31:0];
  endfunction

  function automatic tt_pkg::res_word_t track_event(tt_pkg::evt_word_t e);
    tt_pkg::res_word_t r;
    logic [63:0] ts, last, first, span, len, now, diff, d, k, rem;
    ts = 64'(e.timestamp_ms);
    r = '0;
    if (e.cmd == tt_pkg::CMD_TAP) begin
      if (taps_held > 0) begin
        last = 64'(tap_times[taps_held-1]);
        if (ts >= last && ts - last >= 64'(timeout_q)) taps_held = 0;
      end
      anchor_q = tt_pkg::ANC_W'((ts << 16) & MASK56);
      if (taps_held >= tt_pkg::HIST_DEPTH) begin
        for (int i = 0; i < tt_pkg::HIST_DEPTH - 1; i++) tap_times[i] = tap_times[i+1];
        taps_held = tt_pkg::HIST_DEPTH - 1;
      end
      tap_times[taps_held] = ts[tt_pkg::TS_W-1:0];
      taps_held++;
      if (taps_held >= 2) begin
        first = 64'(tap_times[0]);
        last = 64'(tap_times[taps_held-1]);
        span = (last >= first) ? last - first : 64'd0;
        len = (span << 16) / 64'(taps_held - 1);
        beat_len = (len > 64'hFFFF_FFFF) ? tt_pkg::SAT32 : len[31:0];
        tempo_q = tempo_for(beat_len);
      end
      r.beat_pulse = 1'b1;
    end else if (beat_len != 0) begin
      now = (ts << 16) & MASK56;
      if (!tick_seen) begin
        tick_seen = 1'b1;
        anchor_q = now[tt_pkg::ANC_W-1:0];
        beats_q = '0;
      end
      diff = (now >= 64'(anchor_q)) ? now - 64'(anchor_q) : 64'd0;
      d = 64'(beat_len);
      k = (diff > 0) ? (diff - 1) / d : 64'd0;
      rem = diff - k * d;
      r.beat_pulse = (k > 0);
      anchor_q = tt_pkg::ANC_W'((64'(anchor_q) + k * d) & MASK56);
      beats_q = beats_q + k[31:0];
      phase_q = tt_pkg::PHASE_W'((rem << 16) / d);
      r.sync_updated = 1'b1;
    end
    r.bpm_value = tempo_q;
    r.beat_total = beats_q;
    r.beat_phase = phase_q;
    return r;
  endfunction

  task automatic report(string what, tt_pkg::res_word_t got, tt_pkg::res_word_t want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  task automatic send_word(logic cmd, logic [tt_pkg::TS_W-1:0] ts, bit typed,
                           tt_pkg::res_word_t want);
    tt_pkg::evt_word_t w;
    tt_pkg::res_word_t p;
    w.cmd = cmd;
    w.timestamp_ms = ts;
    evt_valid <= 1'b1;
    evt_data <= w;
    @(posedge clk);
    while (!evt_ready) @(posedge clk);
    p = track_event(w);
    pending_beats.push_back(typed ? want : p);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      evt_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain();
    evt_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(tt_pkg::cfg_reg_t idx, logic [tt_pkg::LEN_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == tt_pkg::REG_INIT_DUR) begin
      beat_len = val;
      tempo_q = tempo_for(val);
    end else begin
      timeout_q = val[tt_pkg::TMO_W-1:0];
    end
  endtask

  task automatic random_words(int count);
    logic [tt_pkg::TS_W-1:0] now;
    logic cmd;
    int pick;
    now = tt_pkg::TS_W'($urandom_range(0, 100000));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      cmd = tt_pkg::CMD_TICK;
      if (pick < 35) begin
        cmd = tt_pkg::CMD_TAP;
        now += tt_pkg::TS_W'($urandom_range(200, 1500));
      end else if (pick < 78) begin
        now += tt_pkg::TS_W'($urandom_range(1, 300));
      end else if (pick < 84) begin
        cmd = tt_pkg::CMD_TAP;
        now += tt_pkg::TS_W'($urandom_range(1500, 70000));
      end else if (pick < 89) begin
        cmd = 1'($urandom_range(0, 1));
        now -= tt_pkg::TS_W'($urandom_range(0, 3000));
      end else if (pick < 92) begin
        cmd = tt_pkg::CMD_TAP;
      end else if (pick < 96) begin
        now += tt_pkg::TS_W'($urandom_range(0, 5000000));
      end else begin
        cmd = 1'($urandom_range(0, 1));
        now = tt_pkg::TS_W'({$urandom(), $urandom()});
      end
      send_word(cmd, now, 1'b0, NONE);
      if (n == count / 3 && count > 100) drain();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    tt_pkg::res_word_t want;
    if (res_valid && res_ready) begin
      if (pending_beats.size() == 0) begin
        report("unexpected word", res_data, NONE);
      end else begin
        want = pending_beats.pop_front();
        if (res_data.beat_pulse !== want.beat_pulse) report("beat_pulse", res_data, want);
        if (res_data.bpm_value !== want.bpm_value) report("bpm_value", res_data, want);
        if (res_data.beat_total !== want.beat_total) report("beat_total", res_data, want);
        if (res_data.beat_phase !== want.beat_phase) report("beat_phase", res_data, want);
        if (res_data.sync_updated !== want.sync_updated)
          report("sync_updated", res_data, want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      res_ready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (evt_valid && evt_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    evt_valid = 1'b0;
    evt_data = '0;
    cfg_valid = 1'b0;
    cfg_index = tt_pkg::REG_INIT_DUR;
    cfg_data = '0;
    errors = 0;
    quiet = 1'b0;
    idle_cycles = 0;
    taps_held = 0;
    beat_len = tt_pkg::INIT_DUR_RST;
    tempo_q = tempo_for(tt_pkg::INIT_DUR_RST);
    anchor_q = '0;
    tick_seen = 1'b0;
    beats_q = '0;
    phase_q = '0;
    timeout_q = tt_pkg::TIMEOUT_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) send_word(script[i].cmd, script[i].ts, script[i].typed, script[i].want);
    random_words(300);

    write_reg(tt_pkg::REG_INIT_DUR, 32'd0);
    write_reg(tt_pkg::REG_TAP_TIMEOUT, 32'd0);
    random_words(280);

    write_reg(tt_pkg::REG_INIT_DUR, 32'hFFFF_FFFF);
    write_reg(tt_pkg::REG_TAP_TIMEOUT, 32'd65535);
    random_words(280);

    write_reg(tt_pkg::REG_INIT_DUR, 32'd1);
    write_reg(tt_pkg::REG_TAP_TIMEOUT, 32'd1);
    random_words(280);

    write_reg(tt_pkg::REG_INIT_DUR, $urandom());
    write_reg(tt_pkg::REG_TAP_TIMEOUT, $urandom_range(1, 65535));
    random_words(280);

    write_reg(tt_pkg::REG_INIT_DUR, tt_pkg::INIT_DUR_RST);
    write_reg(tt_pkg::REG_TAP_TIMEOUT, 32'(tt_pkg::TIMEOUT_RST));
    quiet = 1'b1;
    random_words(300);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
